// ===== hdl/cssg_pkg.sv =====
// Shared constants, codes and a helper function for the constant speed step generator.
package cssg_pkg;

  localparam int unsigned PosW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CmdW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ValW-1:0] MinIntervalReset = ValW'(1000000);
  localparam logic [ValW-1:0] ElapsedMax = '1;

  typedef enum logic [CmdW-1:0] {
    CmdTick        = 3'd0,
    CmdMoveTo      = 3'd1,
    CmdMoveBy      = 3'd2,
    CmdSetInterval = 3'd3,
    CmdStop        = 3'd4,
    CmdSetPosition = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMinInterval = 2'd0,
    RegStepInvert  = 2'd1,
    RegDirInvert   = 2'd2
  } cfg_reg_e;

  typedef logic signed [PosW-1:0] pos_t;

  // True when a minus b, taken modulo the position width, is strictly positive.
  function automatic logic diff_positive(pos_t a, pos_t b);
    pos_t d;
    d = a - b;
    return (d != '0) && !d[PosW-1];
  endfunction

endpackage

// ===== hdl/constant_speed_step_generator_unit.sv =====
// Top level of the constant speed step/direction generator.
//
// Usage: each word on the input channel is one command: tick (one microsecond
// of time), move_to, move_by, set_interval, stop or set_position. Every
// accepted word yields exactly one result word carrying the step and direction
// pins, a step flag, the position count and a running flag.
// The configuration channel writes min_interval, step_invert and dir_invert by
// index; it is always ready and must only be used while the block is idle.
// A word accepted at one clock edge has its result registered at that edge and
// valid from the next cycle on. Throughput is one word per cycle unless the
// receiver stalls; the whole command is evaluated by one pass of compare and
// increment logic between the state registers and the result register.
// When the receiver stalls, the result register holds its word and the input
// is still accepted in the cycle in which the pending result is taken.
// Reset clears position, target, direction, interval and elapsed time, sets
// min_interval to one second and clears both polarity inversions.
module constant_speed_step_generator_unit
  import cssg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [ValW-1:0]       cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CmdW-1:0]       command_i,
  input  logic signed [31:0]    target_value_i,
  input  logic [31:0]           interval_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  step_pulse_o,
  output logic                  direction_pin_o,
  output logic                  stepped_o,
  output logic signed [31:0]    position_o,
  output logic                  running_o
);

  logic [ValW-1:0] min_interval_q;
  logic            step_invert_q;
  logic            dir_invert_q;

  pos_t            pos_q, pos_d;
  pos_t            target_q, target_d;
  logic            dir_q, dir_d;
  logic [ValW-1:0] interval_q, interval_d;
  logic [ValW-1:0] elapsed_q, elapsed_d;

  logic            out_valid_q;
  logic            step_pulse_q;
  logic            dir_pin_q;
  logic            stepped_q;
  logic signed [31:0] position_q;
  logic            running_q;

  logic            in_fire;
  logic            step_now;
  logic [ValW-1:0] elapsed_inc;
  pos_t            tv;
  pos_t            pos_stepped;
  pos_t            aim;
  logic            do_aim;
  cmd_e            cmd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign cmd         = cmd_e'(command_i);
  assign tv          = PosW'(target_value_i);
  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
  assign pos_stepped = dir_q ? pos_q + pos_t'(1) : pos_q - pos_t'(1);

  always_comb begin
    pos_d      = pos_q;
    target_d   = target_q;
    dir_d      = dir_q;
    interval_d = interval_q;
    elapsed_d  = elapsed_q;
    step_now   = 1'b0;
    aim        = tv;
    do_aim     = 1'b0;
    case (cmd)
      CmdTick: begin
        elapsed_d = elapsed_inc;
        if ((interval_q != '0) && (elapsed_inc >= interval_q)) begin
          step_now  = 1'b1;
          pos_d     = pos_stepped;
          elapsed_d = '0;
          if (target_q == pos_stepped) begin
            interval_d = '0;
          end else begin
            dir_d = diff_positive(target_q, pos_stepped);
          end
        end
      end
      CmdMoveTo: begin
        aim    = tv;
        do_aim = 1'b1;
      end
      CmdMoveBy: begin
        aim    = pos_q + tv;
        do_aim = 1'b1;
      end
      CmdSetInterval: begin
        if (interval_i == '0) begin
          interval_d = '0;
        end else begin
          interval_d = (interval_i < min_interval_q) ? min_interval_q : interval_i;
        end
      end
      CmdStop: begin
        interval_d = '0;
        target_d   = pos_q;
      end
      CmdSetPosition: begin
        pos_d      = tv;
        target_d   = tv;
        interval_d = '0;
      end
      default: begin
      end
    endcase
    if (do_aim && (aim != target_q)) begin
      dir_d    = diff_positive(aim, target_q);
      target_d = aim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q <= MinIntervalReset;
      step_invert_q  <= 1'b0;
      dir_invert_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegMinInterval: min_interval_q <= cfg_data_i;
        RegStepInvert:  step_invert_q  <= cfg_data_i[0];
        RegDirInvert:   dir_invert_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      target_q    <= '0;
      dir_q       <= 1'b0;
      interval_q  <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_q      <= pos_d;
        target_q   <= target_d;
        dir_q      <= dir_d;
        interval_q <= interval_d;
        elapsed_q  <= elapsed_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stepped_q    <= step_now;
      step_pulse_q <= step_now ^ step_invert_q;
      dir_pin_q    <= dir_d ^ dir_invert_q;
      position_q   <= 32'(pos_d);
      running_q    <= (target_d != pos_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_pulse_o    = step_pulse_q;
  assign direction_pin_o = dir_pin_q;
  assign stepped_o       = stepped_q;
  assign position_o      = position_q;
  assign running_o       = running_q;

  a_no_step_when_halted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (interval_q == '0) |=> !stepped_q)
    else $error("Step made while the interval was zero.");

  a_no_step_on_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (command_i != CmdTick) |=> !stepped_q && $stable(elapsed_q))
    else $error("Non-tick command stepped or advanced time.");

  a_step_clears_elapsed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && step_now |=> (elapsed_q == '0) && stepped_q)
    else $error("Elapsed time not cleared after a step.");

  a_stop_halts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (command_i == CmdStop) |=> !running_q && (interval_q == '0))
    else $error("Stop left the block running.");

  a_stall_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(pos_q) && $stable(target_q) && $stable(interval_q))
    else $error("State changed without an accepted word.");

endmodule
